[rtl/slab_alloc_pkg.sv]
// Shared constants for the slab slot allocator: field widths, status and
// occupancy codes, register indexes. No dependencies.
package slab_alloc_pkg;

   localparam int WORD_BITS = 32;
   localparam int BIT_W     = 5;

   localparam int OFFSET_W  = 24;
   localparam int SIZE_W    = 16;
   localparam int COUNT_W   = 9;
   localparam int INDEX_W   = 8;
   localparam int CSR_IDX_W = 8;
   localparam int DIV_STEPS = 24;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK            = 2'd0;
   localparam logic [1:0] ST_FULL          = 2'd1;
   localparam logic [1:0] ST_NOT_ALLOCATED = 2'd2;
   localparam logic [1:0] ST_OUT_OF_RANGE  = 2'd3;

   localparam logic [1:0] OCC_EMPTY   = 2'd0;
   localparam logic [1:0] OCC_PARTIAL = 2'd1;
   localparam logic [1:0] OCC_FULL    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OBJECT_SIZE = 8'd1;

   localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET  = 9'd256;
   localparam logic [SIZE_W-1:0]  OBJECT_SIZE_RESET = 16'd32;

endpackage

[rtl/slab_bitmap_slot_allocator_core.sv]
// Slab slot allocator top level: request sequencer, used-slot bitmap RAM and
// offset divider. Depends on slab_alloc_pkg, slab_alloc_ram, slab_alloc_div.
//
// One request is in work at a time. An allocate scans the bitmap RAM one
// 32-bit word at a time (read, then examine and write back) until it finds
// a slot or reports the slab full. A free runs the offset divider, then one
// read-modify-write of a single word; with a zero object size it skips both
// and reports out of range. A further request is taken while the previous
// result waits on rsp_stall. The bitmap needs no clearing pass: a per-word
// valid bit makes unwritten words read as free after reset. Register writes
// are taken on any cycle.
module slab_bitmap_slot_allocator_core
   import slab_alloc_pkg::*;
#(
   parameter int MAX_SLOTS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic [OFFSET_W-1:0]  req_byte_offset,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [INDEX_W-1:0]   rsp_slot_index,
   output logic [OFFSET_W-1:0]  rsp_slot_offset,
   output logic [COUNT_W-1:0]   rsp_used_slots,
   output logic [1:0]           rsp_occupancy
);

   localparam int WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WAW   = WORDS > 1 ? $clog2(WORDS) : 1;
   localparam int WCW   = $clog2(WORDS + 1);
   localparam int IDXW  = $clog2(MAX_SLOTS);
   localparam int CNTW  = $clog2(MAX_SLOTS + 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN_RD = 3'd1;
   localparam logic [2:0] S_SCAN_EX = 3'd2;
   localparam logic [2:0] S_DIV     = 3'd3;
   localparam logic [2:0] S_FREE_EX = 3'd4;
   localparam logic [2:0] S_DONE    = 3'd5;

   logic [2:0]          state_ff,   state_in;
   logic [WCW-1:0]      wcnt_ff,    wcnt_in;
   logic [WAW-1:0]      addr_ff,    addr_in;
   logic [IDXW-1:0]     idx_ff,     idx_in;
   logic [1:0]          status_ff,  status_in;
   logic [CNTW-1:0]     counter_ff, counter_in;
   logic                rd_valid_ff;
   logic [WORDS-1:0]    word_valid_ff;
   logic [COUNT_W-1:0]  slot_count_ff;
   logic [SIZE_W-1:0]   object_size_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   logic [COUNT_W-1:0]  rsp_used_ff;
   logic [1:0]          rsp_occ_ff;

   logic                ram_we;
   logic [WORD_BITS-1:0] ram_wdata;
   logic                ram_re;
   logic [WAW-1:0]      ram_raddr;
   logic [WORD_BITS-1:0] ram_rdata;
   logic [WORD_BITS-1:0] cur_word;

   logic                div_start;
   logic                div_done;
   logic [OFFSET_W-1:0] div_quotient;

   logic [CNTW-1:0]     eff_count;
   logic [31:0]         base;
   logic [WORD_BITS-1:0] free_vec;
   logic                found;
   logic [BIT_W-1:0]    found_pos;
   logic                req_take;
   logic                rsp_load;
   logic [1:0]          occ;
   logic [IDXW+SIZE_W-1:0] product;

   assign eff_count = (32'(slot_count_ff) > 32'(MAX_SLOTS)) ? CNTW'(MAX_SLOTS)
                                                           : CNTW'(slot_count_ff);
   assign base      = 32'(wcnt_ff) * WORD_BITS;
   assign cur_word  = rd_valid_ff ? ram_rdata : '0;
   assign req_take  = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   always_comb begin
      free_vec  = '0;
      found     = 1'b0;
      found_pos = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         free_vec[b] = !cur_word[b] && ((base + 32'(b)) < 32'(eff_count));
      end
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_vec[b]) begin
            found     = 1'b1;
            found_pos = BIT_W'(b);
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      wcnt_in    = wcnt_ff;
      addr_in    = addr_ff;
      idx_in     = idx_ff;
      status_in  = status_ff;
      counter_in = counter_ff;
      ram_we     = 1'b0;
      ram_wdata  = cur_word;
      ram_re     = 1'b0;
      ram_raddr  = addr_ff;
      div_start  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               status_in = ST_OK;
               wcnt_in   = '0;
               if (req_operation == OP_ALLOC) begin
                  state_in = S_SCAN_RD;
               end else if (object_size_ff == '0) begin
                  status_in = ST_OUT_OF_RANGE;
                  state_in  = S_DONE;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_SCAN_RD: begin
            if (wcnt_ff == WCW'(WORDS) || base >= 32'(eff_count)) begin
               status_in = ST_FULL;
               state_in  = S_DONE;
            end else begin
               addr_in   = wcnt_ff[WAW-1:0];
               ram_re    = 1'b1;
               ram_raddr = wcnt_ff[WAW-1:0];
               state_in  = S_SCAN_EX;
            end
         end
         S_SCAN_EX: begin
            if (found) begin
               ram_we               = 1'b1;
               ram_wdata[found_pos] = 1'b1;
               idx_in               = IDXW'(base + 32'(found_pos));
               counter_in           = counter_ff + 1'b1;
               state_in             = S_DONE;
            end else begin
               wcnt_in  = wcnt_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (32'(div_quotient) >= 32'(eff_count)) begin
                  status_in = ST_OUT_OF_RANGE;
                  state_in  = S_DONE;
               end else begin
                  idx_in    = IDXW'(div_quotient);
                  addr_in   = WAW'(div_quotient >> BIT_W);
                  ram_re    = 1'b1;
                  ram_raddr = WAW'(div_quotient >> BIT_W);
                  state_in  = S_FREE_EX;
               end
            end
         end
         S_FREE_EX: begin
            if (cur_word[idx_ff[BIT_W-1:0]]) begin
               ram_we                        = 1'b1;
               ram_wdata[idx_ff[BIT_W-1:0]]  = 1'b0;
               if (counter_ff != '0) begin
                  counter_in = counter_ff - 1'b1;
               end
            end else begin
               status_in = ST_NOT_ALLOCATED;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         counter_ff     <= '0;
         word_valid_ff  <= '0;
         rd_valid_ff    <= 1'b0;
         slot_count_ff  <= SLOT_COUNT_RESET;
         object_size_ff <= OBJECT_SIZE_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         counter_ff <= counter_in;
         if (ram_re) begin
            rd_valid_ff <= word_valid_ff[ram_raddr];
         end
         if (ram_we) begin
            word_valid_ff[addr_ff] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SLOT_COUNT) begin
               slot_count_ff <= csr_data[COUNT_W-1:0];
            end else if (csr_index == CSR_OBJECT_SIZE) begin
               object_size_ff <= csr_data;
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      wcnt_ff   <= wcnt_in;
      addr_ff   <= addr_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
   end

   assign product = IDXW'(idx_ff) * object_size_ff;

   always_comb begin
      if (counter_ff == '0) begin
         occ = OCC_EMPTY;
      end else if (counter_ff >= eff_count) begin
         occ = OCC_FULL;
      end else begin
         occ = OCC_PARTIAL;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_index_ff  <= (status_ff == ST_OK) ? INDEX_W'(idx_ff) : '0;
         rsp_offset_ff <= (status_ff == ST_OK) ? OFFSET_W'(product) : '0;
         rsp_used_ff   <= COUNT_W'(counter_ff);
         rsp_occ_ff    <= occ;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_index  = rsp_index_ff;
   assign rsp_slot_offset = rsp_offset_ff;
   assign rsp_used_slots  = rsp_used_ff;
   assign rsp_occupancy   = rsp_occ_ff;

   slab_alloc_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(WORDS)
   ) u_bitmap (
      .clock (clock),
      .we    (ram_we),
      .waddr (addr_ff),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   slab_alloc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_byte_offset),
      .divisor  (object_size_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

`ifndef SYNTHESIS
   a_counter_bound: assert property (@(posedge clock) disable iff (reset)
      32'(counter_ff) <= 32'(MAX_SLOTS))
      else $error("used counter above slot capacity");
   a_write_in_modify: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_SCAN_EX || state_ff == S_FREE_EX))
      else $error("bitmap written outside a modify cycle");
   a_alloc_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_EX && ram_we) |=> counter_ff == $past(counter_ff) + 1'b1)
      else $error("allocate did not bump used counter");
   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside divide state");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_slot_index == '0 && rsp_slot_offset == '0)
      else $error("error result carries a slot");
`endif

endmodule

[rtl/slab_alloc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module slab_alloc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/slab_alloc_div.sv]
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on slab_alloc_pkg.
module slab_alloc_div
   import slab_alloc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [OFFSET_W-1:0] dividend,
   input  logic [SIZE_W-1:0]   divisor,
   output logic                done,
   output logic [OFFSET_W-1:0] quotient
);

   logic                busy_ff;
   logic                done_ff;
   logic [BIT_W-1:0]    step_ff;
   logic [SIZE_W-1:0]   rem_ff;
   logic [SIZE_W-1:0]   dsr_ff;
   logic [OFFSET_W-1:0] quo_ff;
   logic [SIZE_W:0]     trial;
   logic                take;

   assign trial = {rem_ff, quo_ff[OFFSET_W-1]};
   assign take  = trial >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == BIT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dsr_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= take ? SIZE_W'(trial - {1'b0, dsr_ff}) : trial[SIZE_W-1:0];
         quo_ff <= {quo_ff[OFFSET_W-2:0], take};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef SYNTHESIS
   a_done_one_cycle: assert property (@(posedge clock) disable iff (reset)
      done |=> !done)
      else $error("divider done held more than one cycle");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> !busy_ff)
      else $error("divider done while still busy");
   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |=> busy_ff || done)
      else $error("divider stopped without done");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for slab_bitmap_slot_allocator_core: directed table
// then randomized alloc/free traffic, checked against a bitmap predictor.
// Depends on slab_alloc_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb_top;
   import slab_alloc_pkg::*;

   localparam int SLOTS        = 256;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [1:0]          status;
      logic [INDEX_W-1:0]  slot_index;
      logic [OFFSET_W-1:0] slot_offset;
      logic [COUNT_W-1:0]  used_slots;
      logic [1:0]          occupancy;
   } slot_rsp_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic                  op;
      logic [OFFSET_W-1:0]   offset;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [SIZE_W-1:0]     reg_data;
      bit                    typed;
      slot_rsp_type          want;
   } stim_row_type;

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 csr_valid       = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index       = '0;
   logic [SIZE_W-1:0]    csr_data        = '0;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic                 req_operation   = OP_ALLOC;
   logic [OFFSET_W-1:0]  req_byte_offset = '0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [1:0]           rsp_status;
   logic [INDEX_W-1:0]   rsp_slot_index;
   logic [OFFSET_W-1:0]  rsp_slot_offset;
   logic [COUNT_W-1:0]   rsp_used_slots;
   logic [1:0]           rsp_occupancy;

   // predictor state
   bit   [SLOTS-1:0]     slot_map  = '0;
   logic [COUNT_W-1:0]   used_cnt  = '0;
   logic [COUNT_W-1:0]   cfg_count = SLOT_COUNT_RESET;
   logic [SIZE_W-1:0]    cfg_size  = OBJECT_SIZE_RESET;

   slot_rsp_type  rsp_q[$];
   stim_row_type  dir_tab[$];
   int         errors    = 0;
   int         cycles    = 0;
   bit         quiet     = 1'b0;
   int         hold_req  = 0;

   slab_bitmap_slot_allocator_core #(.MAX_SLOTS(SLOTS)) DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_byte_offset(req_byte_offset),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index),
      .rsp_slot_offset(rsp_slot_offset),
      .rsp_used_slots (rsp_used_slots),
      .rsp_occupancy  (rsp_occupancy)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   function automatic int eff_count();
      return (int'(cfg_count) > SLOTS) ? SLOTS : int'(cfg_count);
   endfunction

   function automatic slot_rsp_type alloc_free_predict(input logic op,
                                                      input logic [OFFSET_W-1:0] off);
      slot_rsp_type r;
      int        lim;
      int        idx;
      int        q;
      bit        found;
      r     = '0;
      idx   = 0;
      found = 1'b0;
      lim   = eff_count();
      r.status = ST_OK;
      if (op == OP_ALLOC) begin
         for (int i = 0; i < lim; i++) begin
            if (!found && !slot_map[i]) begin
               idx   = i;
               found = 1'b1;
            end
         end
         if (found) begin
            slot_map[idx] = 1'b1;
            used_cnt      = used_cnt + 1'b1;
         end else begin
            r.status = ST_FULL;
         end
      end else if (cfg_size == '0) begin
         r.status = ST_OUT_OF_RANGE;
      end else begin
         q = int'(off) / int'(cfg_size);
         if (q >= lim) begin
            r.status = ST_OUT_OF_RANGE;
         end else if (!slot_map[q]) begin
            r.status = ST_NOT_ALLOCATED;
         end else begin
            idx           = q;
            slot_map[idx] = 1'b0;
            if (used_cnt != '0) used_cnt = used_cnt - 1'b1;
         end
      end
      if (r.status == ST_OK) begin
         r.slot_index  = INDEX_W'(idx);
         r.slot_offset = OFFSET_W'(longint'(idx) * longint'(cfg_size));
      end
      r.used_slots = used_cnt;
      if (used_cnt == '0) r.occupancy = OCC_EMPTY;
      else if (int'(used_cnt) >= lim) r.occupancy = OCC_FULL;
      else r.occupancy = OCC_PARTIAL;
      return r;
   endfunction

   function automatic stim_row_type req_row(input logic op, input logic [OFFSET_W-1:0] off);
      stim_row_type r;
      r        = '0;
      r.kind   = ROW_REQ;
      r.op     = op;
      r.offset = off;
      return r;
   endfunction

   function automatic stim_row_type chk_row(input logic op, input logic [OFFSET_W-1:0] off,
                                            input logic [1:0] st,
                                            input logic [INDEX_W-1:0] idx,
                                            input logic [OFFSET_W-1:0] soff,
                                            input logic [COUNT_W-1:0] used,
                                            input logic [1:0] occ);
      stim_row_type r;
      r                  = req_row(op, off);
      r.typed            = 1'b1;
      r.want.status      = st;
      r.want.slot_index  = idx;
      r.want.slot_offset = soff;
      r.want.used_slots  = used;
      r.want.occupancy   = occ;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [SIZE_W-1:0] data);
      stim_row_type r;
      r           = '0;
      r.kind      = ROW_CSR;
      r.reg_index = idx;
      r.reg_data  = data;
      return r;
   endfunction

   // drop valid and wait until every expected word has come back
   task automatic settle();
      req_valid = 1'b0;
      while (rsp_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
      settle();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SLOT_COUNT) cfg_count = data[COUNT_W-1:0];
      else if (idx == CSR_OBJECT_SIZE) cfg_size = data;
      @(negedge clock);
      csr_valid = 1'b0;
      @(negedge clock);
   endtask

   task automatic send_req(input logic op, input logic [OFFSET_W-1:0] off,
                           input bit typed, input slot_rsp_type want);
      slot_rsp_type got;
      while (!quiet && $urandom_range(99) < 23) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_operation   = op;
      req_byte_offset = off;
      do @(posedge clock); while (req_stall);
      got = alloc_free_predict(op, off);
      rsp_q.push_back(typed ? want : got);
      @(negedge clock);
   endtask

   task automatic run_phase(input logic [SIZE_W-1:0] count_word, input logic [SIZE_W-1:0] size,
                            input int n_items, input int alloc_pct, input bit no_idle,
                            input bit hold, input bit pause);
      logic                op;
      logic [OFFSET_W-1:0] off;
      int                  lim;
      int                  idx;
      int                  held[$];
      write_reg(CSR_SLOT_COUNT, count_word);
      write_reg(CSR_OBJECT_SIZE, size);
      quiet = no_idle;
      if (hold) hold_req++;
      for (int k = 0; k < n_items; k++) begin
         if (pause && k == n_items / 2) settle();
         off = OFFSET_W'($urandom());
         lim = eff_count();
         held.delete();
         for (int i = 0; i < lim; i++) if (slot_map[i]) held.push_back(i);
         if ($urandom_range(99) < alloc_pct) begin
            op = OP_ALLOC;
         end else begin
            op = OP_FREE;
            if ($urandom_range(99) < 80 && held.size() != 0 && cfg_size != '0) begin
               idx = held[$urandom_range(held.size() - 1)];
               off = OFFSET_W'(idx * int'(cfg_size) + int'($urandom_range(int'(cfg_size) - 1)));
            end else if ($urandom_range(1) == 1 && lim != 0) begin
               idx = int'($urandom_range(lim - 1));
               off = OFFSET_W'(idx * int'(cfg_size));
            end
         end
         send_req(op, off, 1'b0, '0);
      end
      quiet = 1'b0;
   endtask

   task automatic check_field(input string name, input logic [OFFSET_W-1:0] want,
                              input logic [OFFSET_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      slot_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_q.size() == 0) begin
            $error("result word with none expected: status %0d", rsp_status);
            errors++;
         end else begin
            want = rsp_q.pop_front();
            check_field("status", OFFSET_W'(want.status), OFFSET_W'(rsp_status));
            check_field("slot_index", OFFSET_W'(want.slot_index), OFFSET_W'(rsp_slot_index));
            check_field("slot_offset", want.slot_offset, rsp_slot_offset);
            check_field("used_slots", OFFSET_W'(want.used_slots), OFFSET_W'(rsp_used_slots));
            check_field("occupancy", OFFSET_W'(want.occupancy), OFFSET_W'(rsp_occupancy));
         end
      end
   end

   initial begin : receiver
      int hold_done;
      hold_done = 0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_done) begin
            rsp_stall = 1'b1;
            for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clock);
            hold_done++;
         end else begin
            rsp_stall = !quiet && ($urandom_range(99) < 23);
         end
      end
   end

   initial begin : stimulus
      stim_row_type row;
      int        r;
      int        cnt;
      int        sz;

      dir_tab.push_back(chk_row(OP_ALLOC, 24'd0, ST_OK, 8'd0, 24'd0, 9'd1, OCC_PARTIAL));
      dir_tab.push_back(chk_row(OP_ALLOC, 24'hFFFFFF, ST_OK, 8'd1, 24'd32, 9'd2, OCC_PARTIAL));
      dir_tab.push_back(chk_row(OP_FREE, 24'd32, ST_OK, 8'd1, 24'd32, 9'd1, OCC_PARTIAL));
      dir_tab.push_back(chk_row(OP_FREE, 24'd63, ST_NOT_ALLOCATED, 8'd0, 24'd0, 9'd1,
                                OCC_PARTIAL));
      dir_tab.push_back(chk_row(OP_FREE, 24'hFFFFFF, ST_OUT_OF_RANGE, 8'd0, 24'd0, 9'd1,
                                OCC_PARTIAL));
      dir_tab.push_back(chk_row(OP_FREE, 24'd31, ST_OK, 8'd0, 24'd0, 9'd0, OCC_EMPTY));
      dir_tab.push_back(chk_row(OP_FREE, 24'd0, ST_NOT_ALLOCATED, 8'd0, 24'd0, 9'd0, OCC_EMPTY));
      dir_tab.push_back(csr_row(CSR_SLOT_COUNT, 16'd1));
      dir_tab.push_back(chk_row(OP_ALLOC, 24'd0, ST_OK, 8'd0, 24'd0, 9'd1, OCC_FULL));
      dir_tab.push_back(chk_row(OP_ALLOC, 24'd0, ST_FULL, 8'd0, 24'd0, 9'd1, OCC_FULL));
      // zero slots: alloc full, free out of range
      dir_tab.push_back(csr_row(CSR_SLOT_COUNT, 16'd0));
      dir_tab.push_back(chk_row(OP_ALLOC, 24'd0, ST_FULL, 8'd0, 24'd0, 9'd1, OCC_FULL));
      dir_tab.push_back(chk_row(OP_FREE, 24'd0, ST_OUT_OF_RANGE, 8'd0, 24'd0, 9'd1, OCC_FULL));
      // count above max saturates
      dir_tab.push_back(csr_row(CSR_SLOT_COUNT, 16'h01FF));
      dir_tab.push_back(chk_row(OP_FREE, 24'd0, ST_OK, 8'd0, 24'd0, 9'd0, OCC_EMPTY));
      dir_tab.push_back(csr_row(CSR_SLOT_COUNT, 16'd0));
      dir_tab.push_back(chk_row(OP_ALLOC, 24'd0, ST_FULL, 8'd0, 24'd0, 9'd0, OCC_EMPTY));
      dir_tab.push_back(csr_row(CSR_SLOT_COUNT, 16'd256));
      // zero object size
      dir_tab.push_back(csr_row(CSR_OBJECT_SIZE, 16'd0));
      dir_tab.push_back(chk_row(OP_ALLOC, 24'd0, ST_OK, 8'd0, 24'd0, 9'd1, OCC_PARTIAL));
      dir_tab.push_back(chk_row(OP_FREE, 24'd0, ST_OUT_OF_RANGE, 8'd0, 24'd0, 9'd1,
                                OCC_PARTIAL));
      dir_tab.push_back(csr_row(CSR_OBJECT_SIZE, 16'hFFFF));
      dir_tab.push_back(chk_row(OP_ALLOC, 24'd0, ST_OK, 8'd1, 24'd65535, 9'd2, OCC_PARTIAL));
      dir_tab.push_back(chk_row(OP_FREE, 24'd131069, ST_OK, 8'd1, 24'd65535, 9'd1,
                                OCC_PARTIAL));
      // unknown register indexes are dropped
      dir_tab.push_back(csr_row(8'hFF, 16'h0000));
      dir_tab.push_back(csr_row(8'd2, 16'hFFFF));
      dir_tab.push_back(chk_row(OP_ALLOC, 24'd0, ST_OK, 8'd1, 24'd65535, 9'd2, OCC_PARTIAL));
      dir_tab.push_back(req_row(OP_ALLOC, 24'h5A5A5A));
      // count lowered under the used slots
      dir_tab.push_back(csr_row(CSR_SLOT_COUNT, 16'd2));
      dir_tab.push_back(chk_row(OP_FREE, 24'd131070, ST_OUT_OF_RANGE, 8'd0, 24'd0, 9'd3,
                                OCC_FULL));
      dir_tab.push_back(chk_row(OP_ALLOC, 24'd0, ST_FULL, 8'd0, 24'd0, 9'd3, OCC_FULL));
      dir_tab.push_back(chk_row(OP_FREE, 24'd0, ST_OK, 8'd0, 24'd0, 9'd2, OCC_FULL));
      dir_tab.push_back(req_row(OP_ALLOC, 24'h000000));
      dir_tab.push_back(csr_row(CSR_SLOT_COUNT, 16'd256));
      dir_tab.push_back(csr_row(CSR_OBJECT_SIZE, 16'd32));
      dir_tab.push_back(req_row(OP_FREE, 24'd64));
      dir_tab.push_back(req_row(OP_ALLOC, 24'hA5A5A5));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[k]) begin
         row = dir_tab[k];
         if (row.kind == ROW_CSR) write_reg(row.reg_index, row.reg_data);
         else send_req(row.op, row.offset, row.typed, row.want);
      end

      run_phase(16'd256, SIZE_W'($urandom_range(65535, 1)), 330, 92, 1'b1, 1'b0, 1'b0);
      run_phase(16'd256, 16'd1, 80, 40, 1'b0, 1'b1, 1'b0);
      run_phase(16'd37, 16'hFFFF, 80, 55, 1'b0, 1'b0, 1'b1);
      run_phase(16'd1, 16'd7, 60, 50, 1'b0, 1'b0, 1'b0);
      run_phase(16'd0, 16'd100, 30, 50, 1'b0, 1'b0, 1'b0);
      run_phase(16'hFFFF, 16'd0, 40, 60, 1'b0, 1'b0, 1'b0);
      run_phase(16'd8, 16'd3, 60, 40, 1'b0, 1'b0, 1'b0);
      for (int p = 0; p < 6; p++) begin
         r = int'($urandom_range(9));
         if (r < 7) cnt = int'($urandom_range(64, 1));
         else if (r < 9) cnt = 256;
         else cnt = int'($urandom_range(511, 257));
         r = int'($urandom_range(9));
         if (r < 5) sz = int'($urandom_range(255, 1));
         else if (r < 9) sz = int'($urandom_range(65535, 1));
         else sz = 0;
         run_phase({7'($urandom_range(127)), 9'(cnt)}, SIZE_W'(sz), 70,
                   int'($urandom_range(70, 30)), 1'b0, 1'b0, p == 2);
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
